/* rtl/assert_macros.svh */
// assertion macros for the rtl files; used by the checker top
// expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/bqbc_pkg.sv */
// package for the bracket and quote balance checker
// types, character codes and defaults; no dependencies
`timescale 1ns / 1ps

package bqbc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int INDEX_WIDTH_DEF = 16;

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;

    typedef enum logic [2:0] {
        ST_BALANCED  = 3'd0,
        ST_MISMATCH  = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_OPEN_QUOTE = 3'd3,
        ST_UNCLOSED  = 3'd4,
        ST_OVERFLOW  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        KIND_PAREN  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2
    } t_kind;

    localparam int KIND_WIDTH = 2;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } t_qmode;

    // stack operation for one accepted word
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stack_cmd;

    typedef struct packed {
        t_status     status;
        logic [15:0] err_index;
        logic [7:0]  err_char;
    } t_result;

    function automatic logic [7:0] kind_char(input t_kind kind);
        logic [7:0] ch;
        unique case (kind)
            KIND_PAREN:  ch = CH_LPAREN;
            KIND_SQUARE: ch = CH_LSQUARE;
            KIND_CURLY:  ch = CH_LCURLY;
            default:     ch = CH_LCURLY;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/bracket_quote_balance_checker.sv */
// the result word of a text is registered before it shows on o_valid
// throughput: one byte per cycle while o_ready is high; top of stack is in registers
//   and the entry below it is read ahead from memory, so push and pop never stall
// o_ready drops only while both the output register and the skid register hold results
// reset (synchronous, active low) clears depth, quote state, counters, error and valids;
//   the stack memory is not cleared, only entries below the depth are ever read
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bracket_quote_balance_checker #(
    parameter int STACK_DEPTH = bqbc_pkg::STACK_DEPTH_DEF,
    parameter int INDEX_WIDTH = bqbc_pkg::INDEX_WIDTH_DEF,
    localparam int DW = $clog2(STACK_DEPTH + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_err_index,
    output logic [7:0]  o_err_char
);

    // ---------------------------------------------------------------
    // input handshake
    // ---------------------------------------------------------------
    logic in_acc;
    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;

    // new words are refused only when the skid stage is occupied
    assign o_ready = !r_skid_valid;
    assign in_acc  = i_valid && o_ready;

    // ---------------------------------------------------------------
    // character decode
    // ---------------------------------------------------------------
    logic            is_elem, is_open, is_quote;
    bqbc_pkg::t_kind kind;

    always_comb begin
        is_elem  = 1'b1;
        is_open  = 1'b0;
        is_quote = 1'b0;
        kind     = bqbc_pkg::KIND_PAREN;
        unique case (i_char_in)
            bqbc_pkg::CH_LPAREN:  is_open = 1'b1;
            bqbc_pkg::CH_RPAREN:  kind = bqbc_pkg::KIND_PAREN;
            bqbc_pkg::CH_LSQUARE: begin
                is_open = 1'b1;
                kind    = bqbc_pkg::KIND_SQUARE;
            end
            bqbc_pkg::CH_RSQUARE: kind = bqbc_pkg::KIND_SQUARE;
            bqbc_pkg::CH_LCURLY: begin
                is_open = 1'b1;
                kind    = bqbc_pkg::KIND_CURLY;
            end
            bqbc_pkg::CH_RCURLY:  kind = bqbc_pkg::KIND_CURLY;
            bqbc_pkg::CH_SQUOTE,
            bqbc_pkg::CH_DQUOTE:  is_quote = 1'b1;
            default:              is_elem = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // checker state
    // ---------------------------------------------------------------
    bqbc_pkg::t_qmode       r_qmode, n_qmode;
    logic [INDEX_WIDTH-1:0] r_qstart, n_qstart;
    logic [INDEX_WIDTH-1:0] r_count, n_count;
    bqbc_pkg::t_status      r_err, n_err;
    logic [INDEX_WIDTH-1:0] r_err_idx, n_err_idx;
    logic [7:0]             r_err_char, n_err_char;

    bqbc_pkg::t_stack_cmd   stk_cmd;
    logic [DW-1:0]          stk_depth;
    bqbc_pkg::t_kind        stk_top_kind;
    logic                   stk_next_nonempty;
    bqbc_pkg::t_kind        stk_next_kind;
    logic [INDEX_WIDTH-1:0] stk_next_idx;

    logic                   res_valid;
    bqbc_pkg::t_result      res;

    always_comb begin
        n_qmode    = r_qmode;
        n_qstart   = r_qstart;
        n_count    = r_count;
        n_err      = r_err;
        n_err_idx  = r_err_idx;
        n_err_char = r_err_char;
        stk_cmd    = '0;
        res_valid  = 1'b0;
        res        = '0;
        if (in_acc) begin
            if (is_elem) begin
                n_count = r_count + INDEX_WIDTH'(1);
                // after the first error only the element count moves until the last byte
                if (r_err == bqbc_pkg::ST_BALANCED) begin
                    priority if (r_qmode == bqbc_pkg::Q_SINGLE) begin
                        if (i_char_in == bqbc_pkg::CH_SQUOTE) begin
                            n_qmode = bqbc_pkg::Q_NONE;
                        end
                    end else if (r_qmode == bqbc_pkg::Q_DOUBLE) begin
                        if (i_char_in == bqbc_pkg::CH_DQUOTE) begin
                            n_qmode = bqbc_pkg::Q_NONE;
                        end
                    end else if (is_quote) begin
                        n_qmode  = (i_char_in == bqbc_pkg::CH_SQUOTE) ?
                                   bqbc_pkg::Q_SINGLE : bqbc_pkg::Q_DOUBLE;
                        n_qstart = r_count;
                    end else if (is_open) begin
                        if (stk_depth == DW'(STACK_DEPTH)) begin
                            n_err      = bqbc_pkg::ST_OVERFLOW;
                            n_err_idx  = r_count;
                            n_err_char = i_char_in;
                        end else begin
                            stk_cmd.push = 1'b1;
                        end
                    end else begin
                        // closer
                        if (stk_depth == '0) begin
                            n_err      = bqbc_pkg::ST_EMPTY;
                            n_err_idx  = r_count;
                            n_err_char = i_char_in;
                        end else if (stk_top_kind != kind) begin
                            n_err      = bqbc_pkg::ST_MISMATCH;
                            n_err_idx  = r_count;
                            n_err_char = i_char_in;
                        end else begin
                            stk_cmd.pop = 1'b1;
                        end
                    end
                end
            end
            if (i_last_char) begin
                // report from the state left by this byte, then clear for the next text
                res_valid = 1'b1;
                priority if (n_err != bqbc_pkg::ST_BALANCED) begin
                    res.status    = n_err;
                    res.err_index = 16'(n_err_idx);
                    res.err_char  = n_err_char;
                end else if (n_qmode != bqbc_pkg::Q_NONE) begin
                    res.status    = bqbc_pkg::ST_OPEN_QUOTE;
                    res.err_index = 16'(n_qstart);
                    res.err_char  = (n_qmode == bqbc_pkg::Q_SINGLE) ?
                                    bqbc_pkg::CH_SQUOTE : bqbc_pkg::CH_DQUOTE;
                end else if (stk_next_nonempty) begin
                    res.status    = bqbc_pkg::ST_UNCLOSED;
                    res.err_index = 16'(stk_next_idx);
                    res.err_char  = bqbc_pkg::kind_char(stk_next_kind);
                end else begin
                    res = '0;
                end
                stk_cmd.clear = 1'b1;
                n_qmode    = bqbc_pkg::Q_NONE;
                n_qstart   = '0;
                n_count    = '0;
                n_err      = bqbc_pkg::ST_BALANCED;
                n_err_idx  = '0;
                n_err_char = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qmode    <= bqbc_pkg::Q_NONE;
            r_qstart   <= '0;
            r_count    <= '0;
            r_err      <= bqbc_pkg::ST_BALANCED;
            r_err_idx  <= '0;
            r_err_char <= '0;
        end else begin
            r_qmode    <= n_qmode;
            r_qstart   <= n_qstart;
            r_count    <= n_count;
            r_err      <= n_err;
            r_err_idx  <= n_err_idx;
            r_err_char <= n_err_char;
        end
    end

    // ---------------------------------------------------------------
    // opener stack
    // ---------------------------------------------------------------
    bqbc_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_stack (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (stk_cmd),
        .i_kind          (kind),
        .i_idx           (r_count),
        .o_depth         (stk_depth),
        .o_top_kind      (stk_top_kind),
        .o_next_nonempty (stk_next_nonempty),
        .o_next_kind     (stk_next_kind),
        .o_next_idx      (stk_next_idx)
    );

    // ---------------------------------------------------------------
    // output register plus skid register
    // ---------------------------------------------------------------
    bqbc_pkg::t_result r_out, n_out;
    bqbc_pkg::t_result r_skid, n_skid;
    logic              out_take;

    assign out_take = r_out_valid && i_ready;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            // no word is accepted here, so no new result
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out.status;
    assign o_err_index = r_out.err_index;
    assign o_err_char  = r_out.err_char;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `ASSERT_RUN(a_skid_behind_out, r_skid_valid |-> r_out_valid, "skid full with empty output")
    `ASSERT_RUN(a_last_clears, (in_acc && i_last_char) |=> (stk_depth == '0 && r_count == '0), "state not cleared after last byte")
    `ASSERT_RUN(a_depth_bound, stk_depth <= DW'(STACK_DEPTH), "stack depth above capacity")

endmodule

/* rtl/bqbc_stack.sv */
// opener stack: top entry in registers, the rest in a memory with a registered read
// depends on bqbc_pkg
`timescale 1ns / 1ps

module bqbc_stack #(
    parameter int STACK_DEPTH = bqbc_pkg::STACK_DEPTH_DEF,
    parameter int INDEX_WIDTH = bqbc_pkg::INDEX_WIDTH_DEF,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
    localparam int DW = $clog2(STACK_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bqbc_pkg::t_stack_cmd    i_cmd,
    input  bqbc_pkg::t_kind         i_kind,
    input  logic [INDEX_WIDTH-1:0]  i_idx,
    output logic [DW-1:0]           o_depth,
    output bqbc_pkg::t_kind         o_top_kind,
    output logic                    o_next_nonempty,
    output bqbc_pkg::t_kind         o_next_kind,
    output logic [INDEX_WIDTH-1:0]  o_next_idx
);

    localparam int EW = bqbc_pkg::KIND_WIDTH + INDEX_WIDTH;

    logic [EW-1:0] mem [STACK_DEPTH];

    logic [DW-1:0] r_depth, n_depth;
    logic [EW-1:0] r_top, n_top;
    logic [EW-1:0] r_below;   // entry just under the top, read ahead

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] depth_m2;

    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        wr_en   = 1'b0;
        if (i_cmd.push) begin
            n_depth = r_depth + DW'(1);
            n_top   = {i_kind, i_idx};
            wr_en   = (r_depth != '0);
        end else if (i_cmd.pop) begin
            n_depth = r_depth - DW'(1);
            n_top   = r_below;
        end
    end

    assign wr_addr  = AW'(r_depth - DW'(1));
    assign depth_m2 = n_depth - DW'(2);
    assign rd_addr  = AW'(depth_m2);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_top;
        end
        // forward the word being pushed down when it is the new below entry
        if (wr_en && (wr_addr == rd_addr)) begin
            r_below <= r_top;
        end else begin
            r_below <= mem[rd_addr];
        end
        r_top <= n_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    assign o_depth         = r_depth;
    assign o_top_kind      = bqbc_pkg::t_kind'(r_top[EW-1 -: bqbc_pkg::KIND_WIDTH]);
    assign o_next_nonempty = (n_depth != '0);
    assign o_next_kind     = bqbc_pkg::t_kind'(n_top[EW-1 -: bqbc_pkg::KIND_WIDTH]);
    assign o_next_idx      = n_top[INDEX_WIDTH-1:0];

endmodule

/* dv/bracket_quote_balance_checker_tb.sv */
// testbench for bracket_quote_balance_checker: byte texts in, one status word per text out
// depends on bqbc_pkg and the rtl of the checker; self-contained, no files read
`timescale 1ns / 1ps

module bracket_quote_balance_checker_tb;

    localparam int unsigned STACK_DEPTH = bqbc_pkg::STACK_DEPTH_DEF;
    localparam int unsigned ITEM_COUNT = 1900;

    // openers sit at even positions, their closers right after them
    localparam logic [7:0] ELEMENT_CHARS [8] = '{
        bqbc_pkg::CH_LPAREN, bqbc_pkg::CH_RPAREN, bqbc_pkg::CH_LSQUARE, bqbc_pkg::CH_RSQUARE,
        bqbc_pkg::CH_LCURLY, bqbc_pkg::CH_RCURLY, bqbc_pkg::CH_SQUOTE, bqbc_pkg::CH_DQUOTE
    };

    localparam bqbc_pkg::t_result BALANCED_RESULT = '{bqbc_pkg::ST_BALANCED, 16'd0, 8'd0};

    // one byte of a hand-written text; the result is only meaningful on the last byte
    typedef struct packed {
        logic [7:0]        ch;
        logic              last;
        bqbc_pkg::t_result want;
    } t_script_row;

    localparam int SCRIPT_LEN = 25;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // no elements at all, lowest byte value
        '{8'h00, 1'b1, BALANCED_RESULT},
        // closer with nothing open
        '{bqbc_pkg::CH_RPAREN, 1'b1,
          '{bqbc_pkg::ST_EMPTY, 16'd0, bqbc_pkg::CH_RPAREN}},
        // wrong closer kind, square against round
        '{bqbc_pkg::CH_LPAREN, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_RSQUARE, 1'b1,
          '{bqbc_pkg::ST_MISMATCH, 16'd1, bqbc_pkg::CH_RSQUARE}},
        // single quote left open, highest byte value ends the text
        '{bqbc_pkg::CH_SQUOTE, 1'b0, BALANCED_RESULT},
        '{8'hFF, 1'b1, '{bqbc_pkg::ST_OPEN_QUOTE, 16'd0, bqbc_pkg::CH_SQUOTE}},
        // bracket inside double quotes is skipped but still counted
        '{bqbc_pkg::CH_DQUOTE, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_LPAREN, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_DQUOTE, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_LCURLY, 1'b1,
          '{bqbc_pkg::ST_UNCLOSED, 16'd3, bqbc_pkg::CH_LCURLY}},
        // first error wins over later openers and an open quote
        '{bqbc_pkg::CH_RPAREN, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_LPAREN, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_DQUOTE, 1'b1,
          '{bqbc_pkg::ST_EMPTY, 16'd0, bqbc_pkg::CH_RPAREN}},
        // open quote is reported ahead of an unclosed opener
        '{bqbc_pkg::CH_LSQUARE, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_SQUOTE, 1'b1,
          '{bqbc_pkg::ST_OPEN_QUOTE, 16'd1, bqbc_pkg::CH_SQUOTE}},
        // all three kinds closed, round and square nested, last byte closes the text
        '{bqbc_pkg::CH_LCURLY, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_RCURLY, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_LPAREN, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_LSQUARE, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_RSQUARE, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_RPAREN, 1'b1, BALANCED_RESULT},
        // double quote left open
        '{bqbc_pkg::CH_DQUOTE, 1'b0, BALANCED_RESULT},
        '{8'h41, 1'b1, '{bqbc_pkg::ST_OPEN_QUOTE, 16'd0, bqbc_pkg::CH_DQUOTE}},
        // curly closer against round opener
        '{bqbc_pkg::CH_LPAREN, 1'b0, BALANCED_RESULT},
        '{bqbc_pkg::CH_RCURLY, 1'b1,
          '{bqbc_pkg::ST_MISMATCH, 16'd1, bqbc_pkg::CH_RCURLY}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_char_in = 8'd0;
    logic        i_last_char = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [15:0] o_err_index;
    logic [7:0]  o_err_char;

    // idle rates in percent of cycles, changed per phase of the run
    int unsigned src_idle_pct = 6;
    int unsigned dst_idle_pct = 53;

    int unsigned fault_count = 0;
    int unsigned items_sent = 0;

    bqbc_pkg::t_result expected_results [$];
    logic [7:0]        text_bytes [$];

    // shadow of the checker state
    logic [7:0]        opener_kind [STACK_DEPTH];
    logic [15:0]       opener_index [STACK_DEPTH];
    int unsigned       open_depth;
    bqbc_pkg::t_qmode  quote_state;
    logic [15:0]       quote_open_idx;
    logic [15:0]       elem_count;
    bqbc_pkg::t_result first_fault;

    always #1 i_clk = ~i_clk;

    bracket_quote_balance_checker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_in   (i_char_in),
        .i_last_char (i_last_char),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_err_index (o_err_index),
        .o_err_char  (o_err_char)
    );

    function automatic bit is_element(input logic [7:0] ch);
        return ch inside {bqbc_pkg::CH_LPAREN, bqbc_pkg::CH_RPAREN,
                          bqbc_pkg::CH_LSQUARE, bqbc_pkg::CH_RSQUARE,
                          bqbc_pkg::CH_LCURLY, bqbc_pkg::CH_RCURLY,
                          bqbc_pkg::CH_SQUOTE, bqbc_pkg::CH_DQUOTE};
    endfunction

    function automatic void clear_tracker();
        open_depth = 0;
        quote_state = bqbc_pkg::Q_NONE;
        quote_open_idx = 16'd0;
        elem_count = 16'd0;
        first_fault = BALANCED_RESULT;
    endfunction

    // advance the shadow state by one byte; returns 1 with the status word on the last byte
    function automatic bit track_byte(input logic [7:0] ch, input logic last,
                                      output bqbc_pkg::t_result res);
        logic [15:0] idx;
        logic [7:0]  want;
        res = BALANCED_RESULT;
        if (is_element(ch)) begin
            idx = elem_count;
            elem_count = elem_count + 16'd1;   // wraps at 16 bits like the element index
            if (first_fault.status != bqbc_pkg::ST_BALANCED) begin
                // error already latched, only the count moves
            end else if (quote_state == bqbc_pkg::Q_SINGLE) begin
                if (ch == bqbc_pkg::CH_SQUOTE) quote_state = bqbc_pkg::Q_NONE;
            end else if (quote_state == bqbc_pkg::Q_DOUBLE) begin
                if (ch == bqbc_pkg::CH_DQUOTE) quote_state = bqbc_pkg::Q_NONE;
            end else if (ch == bqbc_pkg::CH_SQUOTE || ch == bqbc_pkg::CH_DQUOTE) begin
                quote_state = (ch == bqbc_pkg::CH_SQUOTE) ?
                              bqbc_pkg::Q_SINGLE : bqbc_pkg::Q_DOUBLE;
                quote_open_idx = idx;
            end else if (ch inside {bqbc_pkg::CH_LPAREN, bqbc_pkg::CH_LSQUARE,
                                    bqbc_pkg::CH_LCURLY}) begin
                if (open_depth >= STACK_DEPTH) begin
                    first_fault = '{bqbc_pkg::ST_OVERFLOW, idx, ch};
                end else begin
                    opener_kind[open_depth] = ch;
                    opener_index[open_depth] = idx;
                    open_depth++;
                end
            end else begin
                want = (ch == bqbc_pkg::CH_RPAREN) ? bqbc_pkg::CH_LPAREN :
                       (ch == bqbc_pkg::CH_RSQUARE) ? bqbc_pkg::CH_LSQUARE :
                       bqbc_pkg::CH_LCURLY;
                if (open_depth == 0)
                    first_fault = '{bqbc_pkg::ST_EMPTY, idx, ch};
                else if (opener_kind[open_depth - 1] != want)
                    first_fault = '{bqbc_pkg::ST_MISMATCH, idx, ch};
                else
                    open_depth--;
            end
        end
        if (!last) return 1'b0;
        // latched error, then open quote, then innermost unclosed opener
        if (first_fault.status != bqbc_pkg::ST_BALANCED)
            res = first_fault;
        else if (quote_state != bqbc_pkg::Q_NONE)
            res = '{bqbc_pkg::ST_OPEN_QUOTE, quote_open_idx,
                    (quote_state == bqbc_pkg::Q_SINGLE) ?
                    bqbc_pkg::CH_SQUOTE : bqbc_pkg::CH_DQUOTE};
        else if (open_depth != 0)
            res = '{bqbc_pkg::ST_UNCLOSED, opener_index[open_depth - 1],
                    opener_kind[open_depth - 1]};
        clear_tracker();
        return 1'b1;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (is_element(b)) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] any_byte(input int unsigned element_pct);
        if ($urandom_range(0, 99) < element_pct) return ELEMENT_CHARS[$urandom_range(0, 7)];
        return plain_byte();
    endfunction

    // random openers followed by their closers in reverse order
    function automatic void add_nest(input int unsigned levels);
        logic [7:0]  closers [$];
        int unsigned k;
        repeat (levels) begin
            k = $urandom_range(0, 2);
            text_bytes.push_back(ELEMENT_CHARS[2 * k]);
            closers.push_back(ELEMENT_CHARS[2 * k + 1]);
        end
        while (closers.size() != 0) text_bytes.push_back(closers.pop_back());
    endfunction

    // mostly well-formed texts with random content, some broken, a few raw or very deep
    function automatic void compose_text();
        logic [7:0]  closers [$];
        logic [7:0]  q;
        logic [7:0]  b;
        int unsigned pick;
        int unsigned cap;
        int unsigned k;
        int unsigned pos;
        text_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 30)) text_bytes.push_back(any_byte(70));
        end else if (pick < 14) begin
            // straddle the stack limit
            add_nest($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2));
        end else begin
            cap = $urandom_range(1, 12);
            repeat ($urandom_range(1, 24)) begin
                case ($urandom_range(0, 5))
                    0, 1: begin
                        if (closers.size() < cap) begin
                            k = $urandom_range(0, 2);
                            text_bytes.push_back(ELEMENT_CHARS[2 * k]);
                            closers.push_back(ELEMENT_CHARS[2 * k + 1]);
                        end
                    end
                    2: begin
                        if (closers.size() != 0) text_bytes.push_back(closers.pop_back());
                    end
                    3: begin
                        // quoted run, may hold brackets and the other quote
                        q = $urandom_range(0, 1) ? bqbc_pkg::CH_SQUOTE : bqbc_pkg::CH_DQUOTE;
                        text_bytes.push_back(q);
                        repeat ($urandom_range(0, 4)) begin
                            b = any_byte(60);
                            while (b == q) b = any_byte(60);
                            text_bytes.push_back(b);
                        end
                        text_bytes.push_back(q);
                    end
                    default: text_bytes.push_back(plain_byte());
                endcase
            end
            while (closers.size() != 0) text_bytes.push_back(closers.pop_back());
            if (text_bytes.size() == 0) text_bytes.push_back(plain_byte());
            // break about a third of the texts
            if ($urandom_range(0, 2) == 0) begin
                pos = $urandom_range(0, text_bytes.size() - 1);
                case ($urandom_range(0, 3))
                    0: text_bytes[pos] = ELEMENT_CHARS[$urandom_range(0, 7)];
                    1: begin
                        if (text_bytes.size() > 1) text_bytes.delete(pos);
                    end
                    2: text_bytes.insert(pos, ELEMENT_CHARS[$urandom_range(0, 7)]);
                    default: text_bytes.push_back($urandom_range(0, 1) ?
                                                  bqbc_pkg::CH_SQUOTE :
                                                  bqbc_pkg::CH_DQUOTE);
                endcase
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fault_count++;
    endtask

    // drive one byte from a falling edge and hold it until accepted; returns at a falling edge
    task automatic send_word(input logic [7:0] ch, input logic last,
                             input bit scripted, input bqbc_pkg::t_result script_want);
        bqbc_pkg::t_result predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        if (track_byte(ch, last, predicted))
            expected_results.push_back(scripted ? script_want : predicted);
        items_sent++;
        i_valid <= 1'b1;
        i_char_in <= ch;
        i_last_char <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_bytes[i])
            send_word(text_bytes[i], i == text_bytes.size() - 1, 1'b0, BALANCED_RESULT);
    endtask

    // result side stalls at random, new decision every falling edge
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // compare every accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        bqbc_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected: %0d %0d 0x%02h",
                                          o_status, o_err_index, o_err_char));
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                if (o_err_index !== want.err_index)
                    report_mismatch($sformatf("err_index %0d, expected %0d",
                                              o_err_index, want.err_index));
                if (o_err_char !== want.err_char)
                    report_mismatch($sformatf("err_char 0x%02h, expected 0x%02h",
                                              o_err_char, want.err_char));
            end
        end
    end

    initial begin
        int unsigned random_start;
        int unsigned budget;
        int unsigned progress;
        clear_tracker();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hand-written texts: extremes, every error kind but overflow, report order
        for (int r = 0; r < SCRIPT_LEN; r++)
            send_word(SCRIPT[r].ch, SCRIPT[r].last, 1'b1, SCRIPT[r].want);

        // stack exactly full, then one opener too many
        text_bytes.delete();
        add_nest(STACK_DEPTH);
        send_text();
        text_bytes.delete();
        add_nest(STACK_DEPTH + 1);
        send_text();

        // random texts in three idle phases, filling up the byte budget
        random_start = items_sent;
        budget = (ITEM_COUNT > items_sent) ? ITEM_COUNT - items_sent : 0;
        progress = 0;
        while (progress < budget) begin
            if (progress < budget / 3) begin
                src_idle_pct = 6;
                dst_idle_pct = 53;
            end else if (progress < 2 * budget / 3) begin
                src_idle_pct = 53;
                dst_idle_pct = 6;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            compose_text();
            send_text();
            progress = items_sent - random_start;
        end
        i_valid <= 1'b0;

        // drain, then wait on to catch stray words
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
